/* sv/sop_pkg.sv */
// Package: payload structs, pipeline sideband structs and widths for the sphere push-out block
package sop_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int RSUM_W  = 32;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 66;
    localparam int ROOT_W  = 32;
    localparam int NUM_W   = 65;
    localparam int QUO_W   = 33;
    localparam int LANES   = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] my_x;
        logic signed [COORD_W-1:0] my_y;
        logic signed [COORD_W-1:0] my_z;
        logic        [RAD_W-1:0]   my_radius;
        logic                      my_active;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic signed [COORD_W-1:0] other_z;
        logic        [RAD_W-1:0]   other_radius;
        logic                      other_active;
    } t_in;

    typedef struct packed {
        logic                      hit;
        logic                      push_valid;
        logic signed [COORD_W-1:0] push_x;
        logic signed [COORD_W-1:0] push_y;
        logic signed [COORD_W-1:0] push_z;
    } t_out;

    typedef struct packed {
        logic                            both;
        logic                            overlap;
        logic [LANES-1:0]                sgn;
        logic [LANES-1:0][ROOT_W-1:0]    mag;
        logic [RSUM_W-1:0]               rsum;
    } t_sqrt_side;

    typedef struct packed {
        logic             both;
        logic             overlap;
        logic             zero;
        logic [LANES-1:0] sgn;
    } t_div_side;

    localparam int SQRT_SIDE_W = $bits(t_sqrt_side);
    localparam int DIV_SIDE_W  = $bits(t_div_side);

endpackage

/* sv/sop_sqrt.sv */
// Pipelined integer square root, one result bit per stage
module sop_sqrt
    import sop_pkg::*;
#(
    parameter int SIDE_W = SQRT_SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [63:0]       i_s,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STEPS = ROOT_W;

    logic              r_vld  [0:STEPS];
    logic [34:0]       r_rem  [0:STEPS];
    logic [ROOT_W-1:0] r_root [0:STEPS];
    logic [63:0]       r_s    [0:STEPS];
    logic [SIDE_W-1:0] r_side [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_s[0]    <= i_s;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [34:0] n_rem2;
        logic [34:0] n_trial;
        logic        n_ge;

        assign n_rem2  = {r_rem[k][32:0], r_s[k][63:62]};
        assign n_trial = {1'b0, r_root[k], 2'b01};
        assign n_ge    = (n_rem2 >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? (n_rem2 - n_trial) : n_rem2;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_ge};
                r_s[k+1]    <= {r_s[k][61:0], 2'b00};
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_root = r_root[STEPS];
    assign o_side = r_side[STEPS];

endmodule

/* sv/sop_div.sv */
// Pipelined restoring divider, three numerators over one shared divisor
module sop_div
    import sop_pkg::*;
#(
    parameter int SIDE_W = DIV_SIDE_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0]            i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_vld,
    output logic [LANES-1:0][QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int STEPS = QUO_W;

    logic              r_vld  [0:STEPS];
    logic [ROOT_W-1:0] r_den  [0:STEPS];
    logic [SIDE_W-1:0] r_side [0:STEPS];
    logic [ROOT_W-1:0] r_rem  [0:LANES-1][0:STEPS];
    logic [QUO_W-1:0]  r_quo  [0:LANES-1][0:STEPS];
    logic [QUO_W-1:0]  r_low  [0:LANES-1][0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[l][0] <= i_num[l][NUM_W-1:QUO_W];
                r_low[l][0] <= i_num[l][QUO_W-1:0];
                r_quo[l][0] <= '0;
            end
        end

        for (genvar k = 0; k < STEPS; k++) begin : g_step
            logic [ROOT_W:0] n_rem2;
            logic [ROOT_W:0] n_den;
            logic            n_ge;

            assign n_rem2 = {r_rem[l][k], r_low[l][k][QUO_W-1]};
            assign n_den  = {1'b0, r_den[k]};
            assign n_ge   = (n_rem2 >= n_den);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][k+1] <= n_ge ? ROOT_W'(n_rem2 - n_den) : n_rem2[ROOT_W-1:0];
                    r_quo[l][k+1] <= {r_quo[l][k][QUO_W-2:0], n_ge};
                    r_low[l][k+1] <= {r_low[l][k][QUO_W-2:0], 1'b0};
                end
            end
        end

        assign o_quo[l] = r_quo[l][STEPS];
    end

    assign o_vld  = r_vld[STEPS];
    assign o_side = r_side[STEPS];

endmodule

/* sv/sphere_overlap_pushout_top.sv */
// Top level: sphere overlap test and push-out vector pipeline
//
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_ready   | i_data (t_in)
//  result  | out       | o_valid / i_ready   | o_data (t_out)
//
// One transaction enters per cycle while the output is not stalled.
// Path: stages A-C, 32-stage square root, stages D-E, 33-stage divider, output register.
// The whole pipeline advances together; a stall at the output freezes every stage.
// Synchronous active-low reset clears the valid bits only.
module sphere_overlap_pushout_top
    import sop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic en;
    logic r_out_vld;
    t_out r_out;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // stage A
    logic                            r_a_vld;
    logic signed [LANES-1:0][DIFF_W-1:0] r_a_diff;
    logic [RSUM_W-1:0]               r_a_rsum;
    logic                            r_a_both;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_diff[0][DIFF_W-1:0] <= {i_data.my_x[COORD_W-1], i_data.my_x}
                                     - {i_data.other_x[COORD_W-1], i_data.other_x};
            r_a_diff[1][DIFF_W-1:0] <= {i_data.my_y[COORD_W-1], i_data.my_y}
                                     - {i_data.other_y[COORD_W-1], i_data.other_y};
            r_a_diff[2][DIFF_W-1:0] <= {i_data.my_z[COORD_W-1], i_data.my_z}
                                     - {i_data.other_z[COORD_W-1], i_data.other_z};
            r_a_rsum <= {1'b0, i_data.my_radius} + {1'b0, i_data.other_radius};
            r_a_both <= i_data.my_active && i_data.other_active;
        end
    end

    // stage B
    logic                         r_b_vld;
    logic [LANES-1:0][SQ_W-1:0]   r_b_sq;
    logic [LANES-1:0][DIFF_W-1:0] r_b_mag;
    logic [LANES-1:0]             r_b_sgn;
    logic [63:0]                  r_b_rr;
    logic [RSUM_W-1:0]            r_b_rsum;
    logic                         r_b_both;
    logic [LANES-1:0][DIFF_W-1:0] n_b_mag;

    for (genvar l = 0; l < LANES; l++) begin : g_mag
        assign n_b_mag[l] = r_a_diff[l][DIFF_W-1] ? (DIFF_W'(0) - r_a_diff[l]) : r_a_diff[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_b_sq[l]  <= SQ_W'(n_b_mag[l]) * SQ_W'(n_b_mag[l]);
                r_b_sgn[l] <= r_a_diff[l][DIFF_W-1];
            end
            r_b_mag  <= n_b_mag;
            r_b_rr   <= 64'(r_a_rsum) * 64'(r_a_rsum);
            r_b_rsum <= r_a_rsum;
            r_b_both <= r_a_both;
        end
    end

    // stage C
    logic       r_c_vld;
    logic [63:0] r_c_s;
    t_sqrt_side r_c_side;
    logic [SQ_W-1:0] n_c_s;

    assign n_c_s = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_s            <= n_c_s[63:0];
            r_c_side.both    <= r_b_both;
            r_c_side.overlap <= (n_c_s < {2'b00, r_b_rr});
            r_c_side.sgn     <= r_b_sgn;
            r_c_side.rsum    <= r_b_rsum;
            for (int l = 0; l < LANES; l++) begin
                r_c_side.mag[l] <= r_b_mag[l][ROOT_W-1:0];
            end
        end
    end

    logic        sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_sqrt_side  sq_side;

    sop_sqrt #(
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_s     (r_c_s),
        .i_side  (r_c_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage D
    logic                       r_d_vld;
    logic [LANES-1:0][63:0]     r_d_prod;
    logic [ROOT_W-1:0]          r_d_root;
    t_div_side                  r_d_side;
    logic [ROOT_W-1:0]          n_d_num;

    assign n_d_num = sq_side.rsum - sq_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_d_prod[l] <= 64'(sq_side.mag[l]) * 64'(n_d_num);
            end
            r_d_root         <= sq_root;
            r_d_side.both    <= sq_side.both;
            r_d_side.overlap <= sq_side.overlap;
            r_d_side.zero    <= !sq_side.overlap || (sq_root == '0);
            r_d_side.sgn     <= sq_side.sgn;
        end
    end

    // stage E
    logic                       r_e_vld;
    logic [LANES-1:0][NUM_W-1:0] r_e_num;
    logic [ROOT_W-1:0]          r_e_root;
    t_div_side                  r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_e_num[l] <= NUM_W'(r_d_prod[l]) + NUM_W'(r_d_root[ROOT_W-1:1]);
            end
            r_e_root <= r_d_root;
            r_e_side <= r_d_side;
        end
    end

    logic                       dv_vld;
    logic [LANES-1:0][QUO_W-1:0] dv_quo;
    t_div_side                  dv_side;

    sop_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_root),
        .i_side  (r_e_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // saturate, apply sign, force zero push
    logic [LANES-1:0][COORD_W-1:0] n_push;
    localparam logic [QUO_W-1:0] POS_MAX = {2'b00, {(QUO_W-2){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_MAX = {2'b01, {(QUO_W-2){1'b0}}};

    for (genvar l = 0; l < LANES; l++) begin : g_sat
        logic [QUO_W-1:0] n_q;
        always_comb begin
            n_q = dv_quo[l];
            if (dv_side.zero) begin
                n_push[l] = '0;
            end else if (!dv_side.sgn[l]) begin
                if (n_q > POS_MAX) begin
                    n_q = POS_MAX;
                end
                n_push[l] = n_q[COORD_W-1:0];
            end else begin
                if (n_q > NEG_MAX) begin
                    n_q = NEG_MAX;
                end
                n_push[l] = COORD_W'(QUO_W'(0) - n_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit        <= dv_side.overlap && dv_side.both;
            r_out.push_valid <= dv_side.overlap;
            r_out.push_x     <= n_push[0];
            r_out.push_y     <= n_push[1];
            r_out.push_z     <= n_push[2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
